FILE: rtl/pwrc_pkg.sv
package pwrc_pkg;

    // Widths fixed by the field layout
    localparam int CODE_BITS_DEF = 24;
    localparam int CODE_WORD_W   = 24;
    localparam int TICK_W        = 8;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;
    localparam int REG_IDX_W     = 2;

    // Register map indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_SYNC_HIGH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIDE      = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_NARROW    = 2'd3;

    // Register reset values
    localparam logic [TICK_W-1:0] SYNC_HIGH_RST = 8'd1;
    localparam logic [TICK_W-1:0] SYNC_LOW_RST  = 8'd31;
    localparam logic [TICK_W-1:0] WIDE_RST      = 8'd3;
    localparam logic [TICK_W-1:0] NARROW_RST    = 8'd1;

    // Request operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0] sync_high;
        logic [TICK_W-1:0] sync_low;
        logic [TICK_W-1:0] wide;
        logic [TICK_W-1:0] narrow;
    } pwrc_cfg_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic start_rejected;
    } pwrc_result_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_SYNC_HI = 5'b00010,
        PH_SYNC_LO = 5'b00100,
        PH_BIT_HI  = 5'b01000,
        PH_BIT_LO  = 5'b10000
    } pwrc_phase_t;

    // A programmed length of zero behaves as one tick
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

FILE: rtl/pwrc_ifs.sv
interface pwrc_in_if import pwrc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [CODE_WORD_W-1:0] code_word;

    modport source (output valid, output operation, output code_word, input ready);
    modport sink   (input valid, input operation, input code_word, output ready);
endinterface

interface pwrc_out_if import pwrc_pkg::*; ();
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic start_rejected;

    modport source (output valid, output line_level, output busy_res, output frame_done,
                    output start_rejected, input ready);
    modport sink   (input valid, input line_level, input busy_res, input frame_done,
                    input start_rejected, output ready);
endinterface

FILE: rtl/pwrc_regs.sv
module pwrc_regs import pwrc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output pwrc_cfg_t             cfg
);

    pwrc_cfg_t             cfg_reg;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_high <= SYNC_HIGH_RST;
            cfg_reg.sync_low  <= SYNC_LOW_RST;
            cfg_reg.wide      <= WIDE_RST;
            cfg_reg.narrow    <= NARROW_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SYNC_HIGH: cfg_reg.sync_high <= pwdata[TICK_W-1:0];
                REG_SYNC_LOW:  cfg_reg.sync_low  <= pwdata[TICK_W-1:0];
                REG_WIDE:      cfg_reg.wide      <= pwdata[TICK_W-1:0];
                REG_NARROW:    cfg_reg.narrow    <= pwdata[TICK_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_SYNC_HIGH: prdata = APB_DATA_W'(cfg_reg.sync_high);
            REG_SYNC_LOW:  prdata = APB_DATA_W'(cfg_reg.sync_low);
            REG_WIDE:      prdata = APB_DATA_W'(cfg_reg.wide);
            REG_NARROW:    prdata = APB_DATA_W'(cfg_reg.narrow);
            default:       prdata = '0;
        endcase
    end

endmodule

FILE: rtl/pwrc_fsm.sv
module pwrc_fsm import pwrc_pkg::*; #(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   operation,
    input  logic [CODE_WORD_W-1:0] code_word,
    input  pwrc_cfg_t              cfg,
    output pwrc_result_t           result
);

    localparam int BIDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam int EXT_W  = (CODE_BITS > CODE_WORD_W) ? CODE_BITS : CODE_WORD_W;

    pwrc_phase_t           phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_count_reg, tick_count_next;
    logic [BIDX_W-1:0]     bit_index_reg, bit_index_next;
    logic [CODE_BITS-1:0]  code_shift_reg, code_shift_next;
    logic                  pin_level_reg, pin_level_next;

    logic [EXT_W-1:0]      word_ext;
    logic                  cur_bit;
    logic [TICK_W-1:0]     seg_len;
    logic [TICK_W:0]       tick_inc;
    logic                  seg_end;

    // Code loaded on start: low bits kept, missing high bits sent as zeros
    assign word_ext = EXT_W'(code_word);
    assign cur_bit  = code_shift_reg[bit_index_reg];
    assign tick_inc = {1'b0, tick_count_reg} + (TICK_W+1)'(1);
    assign seg_end  = (tick_inc >= {1'b0, seg_len});

    // Length of the current segment
    always_comb
    begin
        case (phase_reg)
            PH_SYNC_HI: seg_len = at_least_one(cfg.sync_high);
            PH_SYNC_LO: seg_len = at_least_one(cfg.sync_low);
            PH_BIT_HI:  seg_len = at_least_one(cur_bit ? cfg.wide : cfg.narrow);
            PH_BIT_LO:  seg_len = at_least_one(cur_bit ? cfg.narrow : cfg.wide);
            default:    seg_len = TICK_W'(1);
        endcase
    end

    // Next state and result for one request
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        code_shift_next = code_shift_reg;
        pin_level_next  = pin_level_reg;
        result          = '0;

        if (accept)
        begin
            if (operation == OP_START)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    result.start_rejected = 1'b1;
                end
                else
                begin
                    code_shift_next = word_ext[CODE_BITS-1:0];
                    bit_index_next  = BIDX_W'(CODE_BITS - 1);
                    tick_count_next = '0;
                    phase_next      = PH_SYNC_HI;
                end
                result.line_level = pin_level_reg;
            end
            else if (phase_reg == PH_IDLE)
            begin
                pin_level_next    = 1'b0;
                result.line_level = 1'b0;
            end
            else
            begin
                result.line_level = (phase_reg == PH_SYNC_HI) || (phase_reg == PH_BIT_HI);
                pin_level_next    = result.line_level;
                tick_count_next   = tick_inc[TICK_W-1:0];
                if (seg_end)
                begin
                    tick_count_next = '0;
                    case (phase_reg)
                        PH_SYNC_HI: phase_next = PH_SYNC_LO;
                        PH_SYNC_LO: phase_next = PH_BIT_HI;
                        PH_BIT_HI:  phase_next = PH_BIT_LO;
                        default:
                        begin
                            if (bit_index_reg == '0)
                            begin
                                phase_next        = PH_IDLE;
                                result.frame_done = 1'b1;
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg - BIDX_W'(1);
                                phase_next     = PH_BIT_HI;
                            end
                        end
                    endcase
                end
            end
        end
        result.busy_res = (phase_next != PH_IDLE);
    end

    // Sender state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            code_shift_reg <= '0;
            pin_level_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            code_shift_reg <= code_shift_next;
            pin_level_reg  <= pin_level_next;
        end
    end

endmodule

FILE: rtl/pwrc_out_buf.sv
module pwrc_out_buf import pwrc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  pwrc_result_t push_data,
    output logic         push_ready,
    pwrc_out_if.source   res
);

    logic         out_valid_reg;
    pwrc_result_t out_data_reg;
    logic         skid_valid_reg;
    pwrc_result_t skid_data_reg;
    logic         out_free;

    // New requests are taken as long as the skid slot is empty
    assign push_ready = !skid_valid_reg;
    assign out_free   = !out_valid_reg || res.ready;

    // Output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        if (!out_free && push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.line_level     = out_data_reg.line_level;
    assign res.busy_res       = out_data_reg.busy_res;
    assign res.frame_done     = out_data_reg.frame_done;
    assign res.start_rejected = out_data_reg.start_rejected;

endmodule

FILE: rtl/pulse_width_remote_code_sender_core.sv
// A result is registered in the output stage, or in its skid slot while that stage is stalled.
// Throughput: one request per cycle while the skid slot is empty; the sender state updates on each accept.
// A two-entry output stage keeps requests flowing while one result waits.
// Reset (rst_n, async, active low) idles the sender, drives the line low,
// empties the output stage and returns the tick registers to their defaults.
module pulse_width_remote_code_sender_core import pwrc_pkg::*; #(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pwrc_in_if.sink               cmd,
    pwrc_out_if.source            status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    pwrc_cfg_t    cfg;
    pwrc_result_t result;
    logic         buf_ready;
    logic         accept;

    assign cmd.ready = buf_ready;
    assign accept    = cmd.valid & buf_ready;

    // Tick length registers
    pwrc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Frame sequencer
    pwrc_fsm #(
        .CODE_BITS (CODE_BITS)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (cmd.operation),
        .code_word (cmd.code_word),
        .cfg       (cfg),
        .result    (result)
    );

    // Result register with skid slot
    pwrc_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (result),
        .push_ready (buf_ready),
        .res        (status)
    );

endmodule

FILE: rtl/pwrc_check.sv
module pwrc_check (
    input logic clk,
    input logic rst_n,
    input logic cmd_ready,
    input logic st_valid,
    input logic st_ready,
    input logic line_level,
    input logic busy_res,
    input logic frame_done,
    input logic start_rejected
);

    // A stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid && !st_ready |=> st_valid && $stable(line_level) && $stable(busy_res)
            && $stable(frame_done) && $stable(start_rejected))
        else $error("stalled result changed");

    // With no result pending the skid slot must be empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !st_valid |-> cmd_ready)
        else $error("request blocked with empty output");

    // A dropped start only happens during a frame, which goes on
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid && start_rejected |-> busy_res && !frame_done)
        else $error("start rejected while idle");

    // The last tick of a frame is a low tick and leaves the sender idle
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid && frame_done |-> !busy_res && !line_level)
        else $error("bad frame end");

endmodule

bind pulse_width_remote_code_sender_core pwrc_check u_pwrc_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_ready      (cmd.ready),
    .st_valid       (status.valid),
    .st_ready       (status.ready),
    .line_level     (status.line_level),
    .busy_res       (status.busy_res),
    .frame_done     (status.frame_done),
    .start_rejected (status.start_rejected)
);
